// ===== src/assert_macros.svh =====
// Assertion helpers used by ets_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is held.
`define ETS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ETS_ASSERT_NEXT(lbl, ante, cons, msg) \
    `ETS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== src/ets_pkg.sv =====
// ----------------------------------------------------------------------------
// ets_pkg
// Shared widths, status codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package ets_pkg;

    localparam int X_W    = 21;
    localparam int TOL_W  = 17;
    localparam int OUT_W  = 40;
    localparam int STAT_W = 2;
    localparam int MAG_W  = 21;
    localparam int HALF_W = 20;
    localparam int PP_W   = HALF_W + MAG_W;
    localparam int PROD_W = OUT_W + MAG_W;

    localparam logic [STAT_W-1:0] STAT_CONVERGED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_TERM_LIM  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SATURATED = 2'd2;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    typedef struct packed {
        logic load;
        logic add_step;
        logic mul_lo;
        logic mul_hi;
        logic div_go;
        logic div_recip;
        logic term_load;
        logic out_load;
    } ets_cmd_t;

    typedef struct packed {
        logic cont;
        logic neg;
        logic div_done;
    } ets_sts_t;

endpackage

// ===== src/ets_div.sv =====
// ----------------------------------------------------------------------------
// ets_div
// Restoring divider, one quotient bit per cycle, quotient held after done.
// ----------------------------------------------------------------------------
module ets_div
    import ets_pkg::*;
#(
    parameter int DW = 53
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DW-1:0]    dividend,
    input  logic [OUT_W-1:0] divisor,
    output logic             done,
    output logic [DW-1:0]    quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [OUT_W-1:0] rem_reg, rem_next;
    logic [OUT_W-1:0] dvs_reg;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [OUT_W:0]   trial;
    logic [OUT_W:0]   diff;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        if (!diff[OUT_W]) begin
            rem_next = diff[OUT_W-1:0];
            quo_next = {quo_reg[DW-2:0], 1'b1};
        end else begin
            rem_next = trial[OUT_W-1:0];
            quo_next = {quo_reg[DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/ets_datapath.sv =====
// ----------------------------------------------------------------------------
// ets_datapath
// Series registers, shared 20x21 multiplier, divider and result register.
// ----------------------------------------------------------------------------
module ets_datapath
    import ets_pkg::*;
#(
    parameter int MAX_TERMS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ets_cmd_t          cmd,
    output ets_sts_t          sts,
    input  logic [X_W-1:0]    x_value,
    input  logic [TOL_W-1:0]  tolerance,
    output logic [OUT_W-1:0]  exp_value,
    output logic [STAT_W-1:0] status
);

    localparam int CW    = $clog2(MAX_TERMS + 1);
    localparam int SH_W  = PROD_W - FRAC_BITS;
    localparam int RCP_W = 2 * FRAC_BITS + 1;
    localparam int DW    = (SH_W > RCP_W) ? SH_W : RCP_W;

    logic              neg_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic [OUT_W-1:0]  sum_reg;
    logic [OUT_W-1:0]  term_reg;
    logic [CW-1:0]     count_reg;
    logic              sat_reg;
    logic [PP_W-1:0]   plo_reg, phi_reg;
    logic [OUT_W-1:0]  out_val_reg;
    logic [STAT_W-1:0] out_stat_reg;

    logic [HALF_W-1:0] mul_a;
    logic [PP_W-1:0]   mul_p;
    logic [OUT_W:0]    sum_ext;
    logic [PROD_W-1:0] prod;
    logic [DW-1:0]     term_num, rcp_num, div_num;
    logic [OUT_W-1:0]  div_dvs;
    logic              div_done;
    logic [DW-1:0]     div_q;
    logic [OUT_W-1:0]  q_clamped;
    logic              term_gt_tol;

    assign mul_a   = cmd.mul_hi ? term_reg[OUT_W-1:HALF_W] : term_reg[HALF_W-1:0];
    assign mul_p   = PP_W'(mul_a) * PP_W'(mag_reg);
    assign sum_ext = {1'b0, sum_reg} + {1'b0, term_reg};
    assign prod    = {phi_reg, {HALF_W{1'b0}}} + PROD_W'(plo_reg);

    assign term_num = DW'(prod >> FRAC_BITS);
    assign rcp_num  = (DW'(1) << (2 * FRAC_BITS)) + DW'(sum_reg >> 1);
    assign div_num  = cmd.div_recip ? rcp_num : term_num;
    assign div_dvs  = cmd.div_recip ? sum_reg : (OUT_W'(count_reg) + OUT_W'(1));

    // quotient may exceed 40 bits for big terms
    assign q_clamped = (div_q > DW'(OUT_MAX)) ? OUT_MAX : div_q[OUT_W-1:0];

    assign term_gt_tol = term_reg > OUT_W'(tolerance);

    ets_div #(
        .DW(DW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_go),
        .dividend (div_num),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            neg_reg   <= x_value[X_W-1];
            mag_reg   <= x_value[X_W-1] ? MAG_W'(-x_value) : MAG_W'(x_value);
            // magnitude of the most negative input is 2^20, fits in MAG_W
            term_reg  <= x_value[X_W-1] ? OUT_W'(MAG_W'(-x_value)) : OUT_W'(x_value);
            sum_reg   <= OUT_W'(1) << FRAC_BITS;
            count_reg <= '0;
            sat_reg   <= 1'b0;
        end else begin
            if (cmd.add_step) begin
                count_reg <= count_reg + CW'(1);
                if (sum_ext[OUT_W]) begin
                    sum_reg <= OUT_MAX;
                    sat_reg <= 1'b1;
                end else begin
                    sum_reg <= sum_ext[OUT_W-1:0];
                end
            end
            if (cmd.term_load) begin
                term_reg <= q_clamped;
            end
        end
        if (cmd.mul_lo) begin
            plo_reg <= mul_p;
        end
        if (cmd.mul_hi) begin
            phi_reg <= mul_p;
        end
        if (cmd.out_load) begin
            out_val_reg <= neg_reg ? q_clamped : sum_reg;
            if (!neg_reg && sat_reg) begin
                out_stat_reg <= STAT_SATURATED;
            end else if (term_gt_tol) begin
                out_stat_reg <= STAT_TERM_LIM;
            end else begin
                out_stat_reg <= STAT_CONVERGED;
            end
        end
    end

    assign sts.cont     = (count_reg < CW'(MAX_TERMS)) && term_gt_tol;
    assign sts.neg      = neg_reg;
    assign sts.div_done = div_done;

    assign exp_value = out_val_reg;
    assign status    = out_stat_reg;

endmodule

// ===== src/ets_ctrl.sv =====
// ----------------------------------------------------------------------------
// ets_ctrl
// Sequencer: series loop, reciprocal step and result handshake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ets_ctrl
    import ets_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  ets_sts_t sts,
    output ets_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_CHECK    = 8'b0000_0010,
        S_MUL_LO   = 8'b0000_0100,
        S_MUL_HI   = 8'b0000_1000,
        S_DIV_GO   = 8'b0001_0000,
        S_DIV_WAIT = 8'b0010_0000,
        S_RCP_WAIT = 8'b0100_0000,
        S_FINISH   = 8'b1000_0000
    } ets_state_t;

    ets_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.cont) begin
                    cmd.add_step = 1'b1;
                    state_next   = S_MUL_LO;
                end else if (sts.neg) begin
                    cmd.div_go    = 1'b1;
                    cmd.div_recip = 1'b1;
                    state_next    = S_RCP_WAIT;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = S_DIV_GO;
            end
            S_DIV_GO: begin
                cmd.div_go = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (sts.div_done) begin
                    cmd.term_load = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_RCP_WAIT: begin
                if (sts.div_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `ETS_ASSERT(a_out_load_free, !cmd.out_load || !m_valid_reg || m_ready, "result overwritten")
    `ETS_ASSERT_NEXT(a_accept_check, s_valid && s_ready, state_reg == S_CHECK, "accept lost")
    `ETS_ASSERT_NEXT(a_div_back, state_reg == S_DIV_WAIT && sts.div_done, state_reg == S_CHECK, "term loop broken")
    `ETS_ASSERT(a_div_only_wait, !sts.div_done || state_reg == S_DIV_WAIT || state_reg == S_RCP_WAIT, "stray divide done")

endmodule

// ===== src/exp_taylor_series_top.sv =====
// ----------------------------------------------------------------------------
// exp_taylor_series_top
// Fixed-point e^x by Taylor series with APB tolerance register.
// ----------------------------------------------------------------------------
// Takes signed Q5.16 x on the s_ channel and returns e^x as unsigned Q24.16
// on the m_ channel, with a status code (0 converged, 1 term limit hit,
// 2 saturated). The series of e^|x| is summed term by term; for negative x
// the rounded reciprocal of the sum is returned. One item is in flight at a
// time; a finished result sits in the output register while the next item
// is taken. At most MAX_TERMS terms are added, and the divider length is
// 45 bits at FRAC_BITS 16. A single bit-per-cycle divider does all the
// divides: every term needs one divide by (n+1), and the final reciprocal
// uses the same unit. The tolerance register sits at byte address 0
// (17 bits, reset 66, Q1.16); write it only while the block is idle.
// ----------------------------------------------------------------------------
module exp_taylor_series_top
    import ets_pkg::*;
#(
    parameter int MAX_TERMS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input item
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [X_W-1:0]    s_x_value,
    // result item
    output logic              m_valid,
    input  logic              m_ready,
    output logic [OUT_W-1:0]  m_exp_value,
    output logic [STAT_W-1:0] m_status,
    // config port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic [TOL_W-1:0] TOL_RESET = 17'd66;

    logic [TOL_W-1:0] tol_reg;
    logic             tol_sel;
    ets_cmd_t         cmd;
    ets_sts_t         sts;

    // one register: bit 2 of the byte address picks it
    assign tol_sel = !paddr[2];
    assign pready  = 1'b1;
    assign prdata  = tol_sel ? 32'(tol_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (psel && penable && pwrite && tol_sel) begin
            tol_reg <= pwdata[TOL_W-1:0];
        end
    end

    ets_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ets_datapath #(
        .MAX_TERMS (MAX_TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .x_value   (s_x_value),
        .tolerance (tol_reg),
        .exp_value (m_exp_value),
        .status    (m_status)
    );

endmodule
